FILE: design/bdpcm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdpcm_pkg
// Shared types and constants of the block-exponent DPCM decoder.
// ---------------------------------------------------------------------------
package bdpcm_pkg;

  // state and field widths
  localparam int ADDR_W   = 21;
  localparam int SUM_W    = 44;
  localparam int FETCH_W  = 20;
  localparam int EXPA_W   = 15;
  localparam int SAMPLE_W = 24;

  // command codes
  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_DECODE  = 1'b1;

  // status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // saturation limits on the sum before the scale by 128
  localparam logic signed [SUM_W-1:0] SUM_POS_LIMIT = 44'sd65535;
  localparam logic signed [SUM_W-1:0] SUM_NEG_LIMIT = -44'sd65536;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // input transaction
  typedef struct packed {
    logic        cmd;
    logic [19:0] start_address;
    logic [7:0]  delta_byte;
    logic [7:0]  exponent_byte;
  } bdpcm_req_t;

  // result transaction
  typedef struct packed {
    logic signed [23:0] sample;
    logic               status;
    logic [19:0]        fetch_address;
    logic [EXPA_W-1:0]  exponent_address;
  } bdpcm_rsp_t;

endpackage : bdpcm_pkg
`default_nettype wire

FILE: design/bdpcm_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bdpcm_step
// Combinational decode of one transaction: next read address, next
// running sum and the result fields.
// ---------------------------------------------------------------------------
module bdpcm_step
  import bdpcm_pkg::*;
#(
  parameter int BANK_BYTES = 1048576
) (
  input  var bdpcm_req_t              item,
  input  var logic [ADDR_W-1:0]       read_address,
  input  var logic signed [SUM_W-1:0] running_sum,
  output var logic [ADDR_W-1:0]       read_address_next,
  output var logic signed [SUM_W-1:0] running_sum_next,
  output var bdpcm_rsp_t              result
);

  localparam logic [ADDR_W-1:0] BANK_END = ADDR_W'(BANK_BYTES);

  logic                    start_bad;
  logic                    read_bad;
  logic [3:0]              expo;
  logic signed [SUM_W-1:0] delta_ext;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [SAMPLE_W-1:0] sample_sat;
  logic                    status;
  logic signed [SAMPLE_W-1:0] sample;

  assign start_bad = {1'b0, item.start_address} >= BANK_END;
  assign read_bad  = read_address >= BANK_END;

  // exponent nibble chosen by address bit 4
  assign expo = read_address[4] ? item.exponent_byte[7:4] : item.exponent_byte[3:0];

  // shift-add into the accumulator, wraps modulo the sum width
  assign delta_ext = SUM_W'(signed'(item.delta_byte));
  assign sum_new   = running_sum + (delta_ext <<< expo);

  // scale by 128 and saturate to 24 bits
  always_comb begin
    if (sum_new > SUM_POS_LIMIT) begin
      sample_sat = SAMPLE_MAX;
    end else if (sum_new < SUM_NEG_LIMIT) begin
      sample_sat = SAMPLE_MIN;
    end else begin
      sample_sat = {sum_new[16:0], 7'b0};
    end
  end

  // command decode and state update
  always_comb begin
    read_address_next = read_address;
    running_sum_next  = running_sum;
    status            = STATUS_OK;
    sample            = '0;
    unique case (item.cmd)
      CMD_RESTART: begin
        if (start_bad) begin
          status = STATUS_REJECT;
        end else begin
          read_address_next = {1'b0, item.start_address[19:4], 4'b0};
          running_sum_next  = '0;
        end
      end
      CMD_DECODE: begin
        if (read_bad) begin
          status = STATUS_REJECT;
        end else begin
          read_address_next = read_address + ADDR_W'(1);
          running_sum_next  = sum_new;
          sample            = sample_sat;
        end
      end
      default: begin
        status = STATUS_REJECT;
      end
    endcase
  end

  // result fields, fetch addresses follow the updated read address
  always_comb begin
    result.sample           = sample;
    result.status           = status;
    result.fetch_address    = read_address_next[FETCH_W-1:0];
    result.exponent_address = read_address_next[FETCH_W-1:5];
  end

endmodule : bdpcm_step
`default_nettype wire

FILE: design/block_exponent_dpcm_decoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// block_exponent_dpcm_decoder
// Block-exponent differential PCM decoder for one wave-memory bank.
// ---------------------------------------------------------------------------
// Each transaction is either a restart, which loads a start address aligned
// down to 16 and clears the accumulator, or a decode, which adds the delta
// byte shifted by its exponent nibble to the accumulator and returns the
// accumulator times 128 saturated to 24 bits. Every transaction gives one
// result, which also carries the next delta and exponent fetch addresses.
// A transaction is registered on entry, decoded in one combinational step
// and registered again at the output; one transaction is accepted every
// cycle while the result side keeps up, and the accumulator and read
// address update as the item leaves the input register.
module block_exponent_dpcm_decoder
  import bdpcm_pkg::*;
#(
  parameter int BANK_BYTES = 1048576
) (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       req_valid,
  output var logic       req_stall,
  input  var bdpcm_req_t req,
  output var logic       rsp_valid,
  input  var logic       rsp_stall,
  output var bdpcm_rsp_t rsp
);

  localparam logic [ADDR_W-1:0] BANK_END = ADDR_W'(BANK_BYTES);

  logic                    hold_valid;
  bdpcm_req_t              hold;
  logic                    advance;
  logic [ADDR_W-1:0]       read_address;
  logic [ADDR_W-1:0]       read_address_next;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] running_sum_next;
  bdpcm_rsp_t              result;

  // handshake between input register and result register
  assign advance   = hold_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = hold_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!req_stall) begin
      hold_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      hold <= req;
    end
  end

  // decode step
  bdpcm_step #(
    .BANK_BYTES (BANK_BYTES)
  ) u_step (
    .item              (hold),
    .read_address      (read_address),
    .running_sum       (running_sum),
    .read_address_next (read_address_next),
    .running_sum_next  (running_sum_next),
    .result            (result)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      read_address <= '0;
      running_sum  <= '0;
    end else if (advance) begin
      read_address <= read_address_next;
      running_sum  <= running_sum_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

`ifndef NO_ASSERTIONS
  // a rejected transaction carries a zero sample
  a_reject_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == STATUS_REJECT) |-> (rsp.sample == '0))
    else $error("rejected transaction with nonzero sample");

  // a good restart leaves the read address aligned to 16
  a_restart_align : assert property (@(posedge clk) disable iff (rst)
    advance && (hold.cmd == CMD_RESTART) && (result.status == STATUS_OK)
    |=> (read_address[3:0] == 4'b0) && (running_sum == '0))
    else $error("restart did not align address or clear sum");

  // reads never run beyond the bank end
  a_addr_bound : assert property (@(posedge clk) disable iff (rst)
    read_address <= BANK_END)
    else $error("read address past bank end");

  // a transaction leaving the input register shows up as a result
  a_advance_out : assert property (@(posedge clk) disable iff (rst)
    advance |=> rsp_valid)
    else $error("advanced transaction lost");
`endif

endmodule : block_exponent_dpcm_decoder
`default_nettype wire

FILE: verif/dpcm_sample_checker.sv
// ---------------------------------------------------------------------------
// dpcm_sample_checker
// Watches both channels of the DPCM decoder, predicts each result and
// compares it field by field with what the block returns.
// ---------------------------------------------------------------------------
module dpcm_sample_checker
  import bdpcm_pkg::*;
#(
  parameter int BANK_BYTES = 1048576
) (
  input  var logic       clk,
  input  var logic       rst,
  input  var logic       req_valid,
  input  var logic       req_stall,
  input  var bdpcm_req_t req,
  input  var logic       rsp_valid,
  input  var logic       rsp_stall,
  input  var bdpcm_rsp_t rsp,
  output int             fail_count,
  output int             outstanding
);

  // mirrored decoder state
  logic [ADDR_W-1:0]       read_addr = '0;
  logic signed [SUM_W-1:0] accum     = '0;

  bdpcm_rsp_t expected_samples[$];

  // advance the mirrored state by one transaction and return its result
  function automatic bdpcm_rsp_t decode_sample(input bdpcm_req_t t);
    bdpcm_rsp_t              r;
    logic [3:0]              expo;
    logic signed [SUM_W-1:0] step;
    longint                  scaled;
    r.sample = '0;
    r.status = STATUS_OK;
    if (t.cmd == CMD_RESTART) begin
      if (t.start_address >= BANK_BYTES) begin
        r.status = STATUS_REJECT;
      end else begin
        read_addr = {1'b0, t.start_address[19:4], 4'b0000};
        accum     = '0;
      end
    end else if (read_addr >= BANK_BYTES) begin
      r.status = STATUS_REJECT;
    end else begin
      // address bit 4 picks the exponent nibble
      expo      = read_addr[4] ? t.exponent_byte[7:4] : t.exponent_byte[3:0];
      step      = {{(SUM_W-8){t.delta_byte[7]}}, t.delta_byte};
      step      = step <<< expo;
      accum     = accum + step;
      read_addr = read_addr + 1'b1;
      // scale by 128 and clamp to 24 bits
      scaled = longint'(accum) * 128;
      if (scaled > longint'(SAMPLE_MAX)) begin
        scaled = longint'(SAMPLE_MAX);
      end else if (scaled < longint'(SAMPLE_MIN)) begin
        scaled = longint'(SAMPLE_MIN);
      end
      r.sample = scaled[SAMPLE_W-1:0];
    end
    r.fetch_address    = read_addr[19:0];
    r.exponent_address = read_addr[19:5];
    return r;
  endfunction

  always @(posedge clk) begin
    bdpcm_rsp_t want;
    if (rst) begin
      read_addr = '0;
      accum     = '0;
      expected_samples.delete();
    end else begin
      // result side first: a result never belongs to this cycle's request
      if (rsp_valid && !rsp_stall) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected result %p", $time, rsp);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (rsp.sample !== want.sample) begin
            $display("%0t: sample expected %0d got %0d", $time, want.sample, rsp.sample);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, rsp.status);
            fail_count++;
          end
          if (rsp.fetch_address !== want.fetch_address) begin
            $display("%0t: fetch_address expected %h got %h", $time,
                     want.fetch_address, rsp.fetch_address);
            fail_count++;
          end
          if (rsp.exponent_address !== want.exponent_address) begin
            $display("%0t: exponent_address expected %h got %h", $time,
                     want.exponent_address, rsp.exponent_address);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        expected_samples.push_back(decode_sample(req));
      end
    end
    outstanding = expected_samples.size();
  end

endmodule : dpcm_sample_checker

FILE: verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the block-exponent DPCM decoder.
// ---------------------------------------------------------------------------
// A directed set covers saturation both ways, both exponent nibbles and a
// run up to and past the bank end; random restart-and-decode runs follow,
// mixed with loose transactions. Both sides idle at random except in one
// quiet stretch. The checker beside the block predicts and compares.
module testbench;
  import bdpcm_pkg::*;

  localparam int BANK_BYTES     = 1048576;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       req_valid = 1'b0;
  logic       rsp_stall = 1'b0;
  logic       req_stall;
  logic       rsp_valid;
  bdpcm_req_t req       = '0;
  bdpcm_rsp_t rsp;

  int fail_count;
  int outstanding;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit quiet       = 1'b0;

  block_exponent_dpcm_decoder #(
    .BANK_BYTES(BANK_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  dpcm_sample_checker #(
    .BANK_BYTES(BANK_BYTES)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // restart transaction; the byte fields carry noise
  function automatic bdpcm_req_t restart_item(input logic [19:0] addr);
    bdpcm_req_t t;
    t.cmd           = CMD_RESTART;
    t.start_address = addr;
    t.delta_byte    = 8'($urandom);
    t.exponent_byte = 8'($urandom);
    return t;
  endfunction

  // decode transaction; the start address carries noise
  function automatic bdpcm_req_t decode_item(input logic [7:0] delta, input logic [7:0] expo);
    bdpcm_req_t t;
    t.cmd           = CMD_DECODE;
    t.start_address = 20'($urandom);
    t.delta_byte    = delta;
    t.exponent_byte = expo;
    return t;
  endfunction

  // exponent byte: mostly small nibbles so the sum stays in range
  function automatic logic [7:0] random_exponent();
    if ($urandom_range(3) == 0) begin
      return 8'($urandom);
    end
    return {4'($urandom_range(3)), 4'($urandom_range(3))};
  endfunction

  // present one transaction at the falling edge, hold until accepted
  task automatic send_item(input bdpcm_req_t t);
    quiet = (items_sent >= 700 && items_sent < 1000);
    while (!quiet && $urandom_range(99) < 12) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= t;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // result side stalls at random outside the quiet stretch
  initial begin
    forever begin
      @(negedge clk);
      rsp_stall <= !quiet && ($urandom_range(99) < 12);
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    forever begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int run_len;
    int kind;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: positive saturation on the low nibble
    send_item(restart_item(20'h00000));
    send_item(decode_item(8'h7f, 8'h0f));
    send_item(decode_item(8'h80, 8'hf0));
    // high nibble, negative saturation, unaligned start
    send_item(restart_item(20'h0001f));
    send_item(decode_item(8'h80, 8'hf0));
    // last block of the bank: run to the end, fetch address wraps, then reject
    send_item(restart_item(20'hfffff));
    for (int i = 0; i < 16; i++) begin
      send_item(decode_item(8'($urandom), random_exponent()));
    end
    send_item(decode_item(8'hff, 8'hff));
    send_item(decode_item(8'h01, 8'h00));

    // random: restart-and-decode runs plus loose transactions
    while (items_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        if ($urandom_range(9) == 0) begin
          // start near the bank end so runs reach it
          send_item(restart_item(20'hfffc0 + 20'($urandom_range(63))));
          run_len = $urandom_range(1, 80);
        end else begin
          send_item(restart_item(20'($urandom)));
          run_len = $urandom_range(1, 40);
        end
        for (int i = 0; i < run_len; i++) begin
          send_item(decode_item(8'($urandom), random_exponent()));
        end
      end else begin
        send_item(decode_item(8'($urandom), 8'($urandom)));
        if ($urandom_range(1) == 0) begin
          send_item(restart_item(20'($urandom)));
        end
      end
    end
    req_valid <= 1'b0;

    // drain, then allow the pipeline to settle
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : testbench

FILE: sim.f
design/bdpcm_pkg.sv
design/bdpcm_step.sv
design/block_exponent_dpcm_decoder.sv
verif/dpcm_sample_checker.sv
verif/testbench.sv
